// ----- hdl/lds_pkg.sv -----
// Shared types and constants for the level to display scale converter.
package lds_pkg;

   localparam int FRAC_BITS  = 16;
   // numerator of the linear modes: (|sample| * k) << FRAC_BITS plus half the divisor
   localparam int PROD_W     = 40;
   localparam int NR_W       = PROD_W + FRAC_BITS;
   localparam int DIV_STEPS  = 32;
   // dB product and its rounded magnitude
   localparam int P_W        = 62;
   localparam int LOG_W      = 63 - (54 - FRAC_BITS);
   localparam logic [32:0] DB_PER_LOG2_Q30 = 33'd6464569932;
   // three front stages, one stage per step, three back stages
   localparam int LATENCY    = 3 + DIV_STEPS + 3;

   typedef enum logic [3:0] {
      MODE_PERCENT = 4'd0,
      MODE_NEGATE  = 4'd1,
      MODE_DB      = 4'd2,
      MODE_DB40    = 4'd3,
      MODE_DIV318  = 4'd4,
      MODE_MOD     = 4'd5,
      MODE_HALF    = 4'd6,
      MODE_DIRECT  = 4'd7,
      MODE_FLOOR   = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      KIND_LIN,
      KIND_DB,
      KIND_MOD40
   } kind_type;

   typedef enum logic [2:0] {
      FIX_NONE,
      FIX_ZERO,
      FIX_INV,
      FIX_M180,
      FIX_P40
   } fix_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      fix_type     fix;
      logic        neg;
      logic        ovf;
      logic        q_top;
      logic [30:0] divisor;
      logic [30:0] rem;
      logic [31:0] qsh;
      logic [4:0]  n_a;
      logic [4:0]  n_b;
      logic [31:0] m_a;
      logic [31:0] m_b;
      logic [31:0] f_a;
      logic [31:0] f_b;
   } step_type;

endpackage

// ----- hdl/lds_front.sv -----
// Input register, mode decode and normalisation ahead of the step chain.
module lds_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [31:0]           sample,
   input  logic [3:0]            mode,
   input  logic [30:0]           full_scale,
   output lds_pkg::step_type     step_out
);

   function automatic logic [4:0] lead_one(input logic [31:0] x);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) n = 5'(i);
      end
      return n;
   endfunction

   // stage A: input register
   logic              a_valid_ff;
   logic [31:0]       a_sample_ff;
   logic [3:0]        a_mode_ff;
   logic [30:0]       a_fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_sample_ff <= sample;
      a_mode_ff   <= mode;
      a_fs_ff     <= (full_scale == 31'd0) ? 31'd1 : full_scale;
   end

   // stage B: magnitude, scale product, log arguments, special cases
   logic                  neg;
   logic [31:0]           mag;
   logic [7:0]            k;
   logic [30:0]           dv;
   logic                  lneg;
   lds_pkg::kind_type     kind;
   lds_pkg::fix_type      fix;
   logic [31:0]           x_a;
   logic [31:0]           x_b;
   logic                  floor_chk;
   logic signed [32:0]    s33;
   logic signed [32:0]    f33;

   always_comb begin
      neg       = a_sample_ff[31];
      mag       = neg ? 32'(-a_sample_ff) : a_sample_ff;
      floor_chk = (42'(mag) * 42'd1000) < 42'(a_fs_ff);
      s33       = $signed({a_sample_ff[31], a_sample_ff});
      f33       = $signed({2'b00, a_fs_ff});
      k         = 8'd1;
      dv        = a_fs_ff;
      lneg      = neg;
      kind      = lds_pkg::KIND_LIN;
      fix       = lds_pkg::FIX_NONE;
      x_a       = mag;
      x_b       = {1'b0, a_fs_ff};
      case (a_mode_ff)
         lds_pkg::MODE_PERCENT: begin
            k = 8'd100;
         end
         lds_pkg::MODE_NEGATE: begin
            dv   = 31'd1;
            lneg = !neg && (mag != 32'd0);
         end
         lds_pkg::MODE_DB: begin
            kind = lds_pkg::KIND_DB;
            if (neg) fix = lds_pkg::FIX_INV;
            else if (mag == 32'd0) fix = lds_pkg::FIX_M180;
         end
         lds_pkg::MODE_DB40: begin
            kind = lds_pkg::KIND_MOD40;
            x_a  = 32'(s33 + f33);
            x_b  = 32'(f33 - s33);
            if (s33 > f33 || s33 <= -f33) fix = lds_pkg::FIX_INV;
            else if (s33 == f33) fix = lds_pkg::FIX_P40;
         end
         lds_pkg::MODE_DIV318: begin
            dv = 31'd318;
         end
         lds_pkg::MODE_MOD: begin
            dv = 31'd340;
         end
         lds_pkg::MODE_HALF: begin
            k = 8'd200;
         end
         lds_pkg::MODE_DIRECT: begin
            dv = 31'd1;
         end
         default: begin
            lneg = 1'b0;
            if (neg || floor_chk) fix = lds_pkg::FIX_ZERO;
         end
      endcase
   end

   logic                          b_valid_ff;
   lds_pkg::kind_type             b_kind_ff;
   lds_pkg::fix_type              b_fix_ff;
   logic                          b_neg_ff;
   logic [lds_pkg::PROD_W-1:0]    b_prod_ff;
   logic [30:0]                   b_div_ff;
   logic [31:0]                   b_xa_ff;
   logic [31:0]                   b_xb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_kind_ff <= kind;
      b_fix_ff  <= fix;
      b_neg_ff  <= lneg;
      b_prod_ff <= lds_pkg::PROD_W'(mag) * lds_pkg::PROD_W'(k);
      b_div_ff  <= dv;
      b_xa_ff   <= x_a;
      b_xb_ff   <= x_b;
   end

   // stage C: overflow check, top quotient bit, log normalisation
   localparam int TOP_W = lds_pkg::NR_W - 33;
   logic [lds_pkg::NR_W-1:0] nr;
   logic [TOP_W-1:0]         top;
   logic [31:0]              t;
   logic                     q_top;
   logic [4:0]               n_a;
   logic [4:0]               n_b;
   lds_pkg::step_type        c_in;
   lds_pkg::step_type        c_ff;

   always_comb begin
      nr    = {b_prod_ff, {lds_pkg::FRAC_BITS{1'b0}}}
              + lds_pkg::NR_W'(b_div_ff >> 1);
      top   = nr[lds_pkg::NR_W-1:33];
      t     = {{(31 - TOP_W){1'b0}}, top, nr[32]};
      q_top = t >= {1'b0, b_div_ff};
      n_a   = lead_one(b_xa_ff);
      n_b   = lead_one(b_xb_ff);
      c_in.valid   = b_valid_ff;
      c_in.kind    = b_kind_ff;
      c_in.fix     = b_fix_ff;
      c_in.neg     = b_neg_ff;
      c_in.ovf     = 32'(top) >= {1'b0, b_div_ff};
      c_in.q_top   = q_top;
      c_in.divisor = b_div_ff;
      c_in.rem     = q_top ? 31'(t - {1'b0, b_div_ff}) : t[30:0];
      c_in.qsh     = nr[31:0];
      c_in.n_a     = n_a;
      c_in.n_b     = n_b;
      c_in.m_a     = b_xa_ff << (5'd31 - n_a);
      c_in.m_b     = b_xb_ff << (5'd31 - n_b);
      c_in.f_a     = 32'd0;
      c_in.f_b     = 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else begin
         c_ff.valid <= c_in.valid;
      end
      c_ff.kind    <= c_in.kind;
      c_ff.fix     <= c_in.fix;
      c_ff.neg     <= c_in.neg;
      c_ff.ovf     <= c_in.ovf;
      c_ff.q_top   <= c_in.q_top;
      c_ff.divisor <= c_in.divisor;
      c_ff.rem     <= c_in.rem;
      c_ff.qsh     <= c_in.qsh;
      c_ff.n_a     <= c_in.n_a;
      c_ff.n_b     <= c_in.n_b;
      c_ff.m_a     <= c_in.m_a;
      c_ff.m_b     <= c_in.m_b;
      c_ff.f_a     <= c_in.f_a;
      c_ff.f_b     <= c_in.f_b;
   end

   assign step_out = c_ff;

endmodule

// ----- hdl/lds_cell.sv -----
// One link of the chain: a quotient bit and a log2 fraction bit for each argument.
module lds_cell (
   input  logic              clock,
   input  logic              reset,
   input  lds_pkg::step_type step_in,
   output lds_pkg::step_type step_out
);

   logic [31:0]       t;
   logic              q;
   logic [63:0]       sq_a;
   logic [63:0]       sq_b;
   logic [32:0]       h_a;
   logic [32:0]       h_b;
   lds_pkg::step_type nxt;
   lds_pkg::step_type step_ff;

   always_comb begin
      nxt  = step_in;
      // restoring division: bring down the next numerator bit
      t    = {step_in.rem, step_in.qsh[31]};
      q    = t >= {1'b0, step_in.divisor};
      nxt.rem = q ? 31'(t - {1'b0, step_in.divisor}) : t[30:0];
      nxt.qsh = {step_in.qsh[30:0], q};
      // squaring: a carry into bit 32 is the next fraction bit
      sq_a = step_in.m_a * step_in.m_a;
      sq_b = step_in.m_b * step_in.m_b;
      h_a  = sq_a[63:31];
      h_b  = sq_b[63:31];
      nxt.m_a = h_a[32] ? h_a[32:1] : h_a[31:0];
      nxt.m_b = h_b[32] ? h_b[32:1] : h_b[31:0];
      nxt.f_a = {step_in.f_a[30:0], h_a[32]};
      nxt.f_b = {step_in.f_b[30:0], h_b[32]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else begin
         step_ff.valid <= nxt.valid;
      end
      step_ff.kind    <= nxt.kind;
      step_ff.fix     <= nxt.fix;
      step_ff.neg     <= nxt.neg;
      step_ff.ovf     <= nxt.ovf;
      step_ff.q_top   <= nxt.q_top;
      step_ff.divisor <= nxt.divisor;
      step_ff.rem     <= nxt.rem;
      step_ff.qsh     <= nxt.qsh;
      step_ff.n_a     <= nxt.n_a;
      step_ff.n_b     <= nxt.n_b;
      step_ff.m_a     <= nxt.m_a;
      step_ff.m_b     <= nxt.m_b;
      step_ff.f_a     <= nxt.f_a;
      step_ff.f_b     <= nxt.f_b;
   end

   assign step_out = step_ff;

endmodule

// ----- hdl/lds_back.sv -----
// Log difference, dB scaling, clamping and saturation to the output registers.
module lds_back (
   input  logic              clock,
   input  logic              reset,
   input  lds_pkg::step_type step_in,
   output logic              rsp_valid,
   output logic [31:0]       rsp_display_value,
   output logic              rsp_invalid,
   output logic              rsp_saturated
);

   localparam logic [32:0] ONE = 33'(1) << lds_pkg::FRAC_BITS;

   // stage D: difference of the two logarithms
   logic [36:0]       la;
   logic [36:0]       lb;
   logic              dneg;
   logic [36:0]       d;

   always_comb begin
      la   = {step_in.n_a, step_in.f_a};
      lb   = {step_in.n_b, step_in.f_b};
      dneg = la < lb;
      d    = dneg ? lb - la : la - lb;
   end

   logic              d_valid_ff;
   logic              e_valid_ff;
   lds_pkg::kind_type d_kind_ff,  e_kind_ff;
   lds_pkg::fix_type  d_fix_ff,   e_fix_ff;
   logic              d_neg_ff,   e_neg_ff;
   logic              d_ovf_ff,   e_ovf_ff;
   logic              d_dneg_ff,  e_dneg_ff;
   logic [32:0]       d_q_ff,     e_q_ff;
   logic [28:0]       d_dsh_ff;
   logic [lds_pkg::P_W-1:0] e_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= step_in.valid;
         e_valid_ff <= d_valid_ff;
      end
      d_kind_ff <= step_in.kind;
      d_fix_ff  <= step_in.fix;
      d_neg_ff  <= step_in.neg;
      d_ovf_ff  <= step_in.ovf;
      d_dneg_ff <= dneg;
      d_q_ff    <= {step_in.q_top, step_in.qsh};
      d_dsh_ff  <= d[36:8];
      // stage E: scale by 20*log10(2)
      e_kind_ff <= d_kind_ff;
      e_fix_ff  <= d_fix_ff;
      e_neg_ff  <= d_neg_ff;
      e_ovf_ff  <= d_ovf_ff;
      e_dneg_ff <= d_dneg_ff;
      e_q_ff    <= d_q_ff;
      e_p_ff    <= lds_pkg::P_W'(d_dsh_ff) * lds_pkg::P_W'(lds_pkg::DB_PER_LOG2_Q30);
   end

   // stage F: rounding, mode limits, saturation
   logic [62:0]              pr;
   logic [lds_pkg::LOG_W-1:0] v;
   logic                     o_neg;
   logic [32:0]              o_mag;
   logic                     o_inv;
   logic                     o_sat;
   logic [32:0]              lim;
   logic [32:0]              signed_mag;

   always_comb begin
      pr    = 63'(e_p_ff) + (63'(1) << (53 - lds_pkg::FRAC_BITS));
      v     = lds_pkg::LOG_W'(pr >> (54 - lds_pkg::FRAC_BITS));
      o_neg = 1'b0;
      o_mag = 33'd0;
      o_inv = 1'b0;
      o_sat = 1'b0;
      case (e_fix_ff)
         lds_pkg::FIX_NONE: begin
            case (e_kind_ff)
               lds_pkg::KIND_DB: begin
                  o_neg = e_dneg_ff && (v != '0);
                  o_mag = 33'(v);
               end
               lds_pkg::KIND_MOD40: begin
                  if (e_dneg_ff || 33'(v) < ONE) o_mag = 33'd0;
                  else if (33'(v) > 33'd40 * ONE) o_mag = 33'd40 * ONE;
                  else o_mag = 33'(v);
               end
               default: begin
                  o_neg = e_neg_ff;
                  o_mag = e_q_ff;
                  o_sat = e_ovf_ff;
               end
            endcase
         end
         lds_pkg::FIX_INV: begin
            o_inv = 1'b1;
         end
         lds_pkg::FIX_M180: begin
            o_neg = 1'b1;
            o_mag = 33'd180 * ONE;
         end
         lds_pkg::FIX_P40: begin
            o_mag = 33'd40 * ONE;
         end
         default: begin
            o_mag = 33'd0;
         end
      endcase
      lim = o_neg ? 33'd2147483648 : 33'd2147483647;
      if (o_sat || o_mag > lim) begin
         o_mag = lim;
         o_sat = 1'b1;
      end
      signed_mag = o_neg ? 33'(-o_mag) : o_mag;
   end

   logic              out_valid_ff;
   logic [31:0]       value_ff;
   logic              inv_ff;
   logic              sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= e_valid_ff;
      end
      value_ff <= signed_mag[31:0];
      inv_ff   <= o_inv;
      sat_ff   <= o_sat;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_display_value = value_ff;
   assign rsp_invalid       = inv_ff;
   assign rsp_saturated     = sat_ff;

endmodule

// ----- hdl/level_to_display_scale_converter.sv -----
// Top level: register port, front stages, chain of step cells and output stages.
//
//  channel   ports                                      direction
//  request   start, busy, req_sample                    in (busy out)
//  result    rsp_valid, rsp_display_value/invalid/sat.  out, one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,      APB slave
//            prdata, pready
//
// A sample may be started on every cycle; busy stays low.
// Each result passes through three front stages, 32 cells
// (one quotient bit and one log2 fraction bit per cell) and three back stages.
// Synchronous reset empties the pipeline and loads mode 7, full scale 2^23.
// Results cannot be stalled; each strobe lasts one cycle.
module level_to_display_scale_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   output logic [31:0] rsp_display_value,
   output logic        rsp_invalid,
   output logic        rsp_saturated,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [3:0]  mode_ff;
   logic [30:0] fs_ff;
   logic        wr;

   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign prdata = paddr[2] ? {1'b0, fs_ff} : {28'd0, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lds_pkg::MODE_DIRECT;
         fs_ff   <= 31'd8388608;
      end else if (wr) begin
         if (paddr[2]) fs_ff <= pwdata[30:0];
         else mode_ff <= pwdata[3:0];
      end
   end

   lds_pkg::step_type chain [0:lds_pkg::DIV_STEPS];

   lds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (start && !busy),
      .sample     (req_sample),
      .mode       (mode_ff),
      .full_scale (fs_ff),
      .step_out   (chain[0])
   );

   for (genvar i = 0; i < lds_pkg::DIV_STEPS; i++) begin : g_chain
      lds_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step_in  (chain[i]),
         .step_out (chain[i+1])
      );
   end

   lds_back u_back (
      .clock             (clock),
      .reset             (reset),
      .step_in           (chain[lds_pkg::DIV_STEPS]),
      .rsp_valid         (rsp_valid),
      .rsp_display_value (rsp_display_value),
      .rsp_invalid       (rsp_invalid),
      .rsp_saturated     (rsp_saturated)
   );

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, lds_pkg::LATENCY))
      else $error("result without a started transaction");
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_display_value == 32'd0))
      else $error("invalid result not zero");
   a_inv_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_invalid && rsp_saturated))
      else $error("invalid and saturated together");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the level to display scale converter.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] ADDR_MODE = 3'd0;
   localparam logic [2:0] ADDR_FULL_SCALE = 3'd4;

   typedef struct {
      logic [31:0] display_value;
      logic        invalid;
      logic        saturated;
   } display_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_sample;
   logic        rsp_valid;
   logic [31:0] rsp_display_value;
   logic        rsp_invalid;
   logic        rsp_saturated;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [3:0]  cur_mode;
   logic [30:0] cur_full_scale;
   display_type expected_q[$];
   int          error_count;
   int          idle_cycles;

   level_to_display_scale_converter DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .rsp_valid(rsp_valid),
      .rsp_display_value(rsp_display_value), .rsp_invalid(rsp_invalid),
      .rsp_saturated(rsp_saturated), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] div_nearest(logic [63:0] num, logic [63:0] den);
      return (num + den / 2) / den;
   endfunction

   function automatic logic [63:0] log2_frac32(logic [63:0] x);
      logic [63:0] n;
      logic [63:0] m;
      logic [63:0] frac;
      n = 64'd0;
      frac = 64'd0;
      if (x == 64'd0) return 64'd0;
      for (int i = 63; i >= 0; i--) begin
         if (x[i] && n == 64'd0) n = 64'(i);
      end
      m = (n >= 64'd31) ? (x >> (n - 64'd31)) : (x << (64'd31 - n));
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (n << 32) | frac;
   endfunction

   function automatic logic [63:0] decibels(logic [63:0] num, logic [63:0] den,
                                            output logic neg);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] d;
      logic [63:0] p;
      a = log2_frac32(num);
      b = log2_frac32(den);
      neg = a < b;
      d = neg ? b - a : a - b;
      p = (d >> 8) * 64'd6464569932;
      return (p + (64'd1 << (53 - lds_pkg::FRAC_BITS))) >> (54 - lds_pkg::FRAC_BITS);
   endfunction

   function automatic display_type pack_display(logic neg, logic [63:0] mag, logic inv);
      display_type r;
      logic [63:0] lim;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      r.saturated = mag > lim;
      if (mag > lim) mag = lim;
      r.display_value = neg ? 32'(64'd0 - mag) : mag[31:0];
      r.invalid = inv;
      return r;
   endfunction

   function automatic display_type convert_sample(logic signed [31:0] sample);
      logic        neg;
      logic        dneg;
      logic [63:0] mag;
      logic [63:0] fs;
      logic [63:0] v;
      logic signed [63:0] s;
      logic signed [63:0] fss;
      logic [63:0] one;
      s = 64'(sample);
      neg = s < 0;
      mag = neg ? -s : s;
      fs = (cur_full_scale == 31'd0) ? 64'd1 : 64'(cur_full_scale);
      fss = fs;
      one = 64'd1 << lds_pkg::FRAC_BITS;
      case (cur_mode)
         lds_pkg::MODE_PERCENT:
            return pack_display(neg, div_nearest((mag * 100) << lds_pkg::FRAC_BITS, fs),
                                1'b0);
         lds_pkg::MODE_NEGATE:
            return pack_display(!neg && mag != 64'd0, mag << lds_pkg::FRAC_BITS, 1'b0);
         lds_pkg::MODE_DB: begin
            if (neg) return pack_display(1'b0, 64'd0, 1'b1);
            if (mag == 64'd0) return pack_display(1'b1, 180 * one, 1'b0);
            v = decibels(mag, fs, dneg);
            return pack_display(dneg && v != 64'd0, v, 1'b0);
         end
         lds_pkg::MODE_DB40: begin
            if (s > fss || s <= -fss) return pack_display(1'b0, 64'd0, 1'b1);
            if (s == fss) return pack_display(1'b0, 40 * one, 1'b0);
            v = decibels(64'(fss + s), 64'(fss - s), dneg);
            if (dneg || v < one) v = 64'd0;
            else if (v > 40 * one) v = 40 * one;
            return pack_display(1'b0, v, 1'b0);
         end
         lds_pkg::MODE_DIV318:
            return pack_display(neg, div_nearest(mag << lds_pkg::FRAC_BITS, 64'd318), 1'b0);
         lds_pkg::MODE_MOD:
            return pack_display(neg, div_nearest(mag << lds_pkg::FRAC_BITS, 64'd340), 1'b0);
         lds_pkg::MODE_HALF:
            return pack_display(neg, div_nearest((mag * 200) << lds_pkg::FRAC_BITS, fs),
                                1'b0);
         lds_pkg::MODE_DIRECT:
            return pack_display(neg, mag << lds_pkg::FRAC_BITS, 1'b0);
         default: begin
            if (neg || mag * 1000 < fs) return pack_display(1'b0, 64'd0, 1'b0);
            return pack_display(1'b0, div_nearest(mag << lds_pkg::FRAC_BITS, fs), 1'b0);
         end
      endcase
   endfunction

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_MODE) cur_mode = data[3:0];
      else cur_full_scale = data[30:0];
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] want);
      psel <= 1'b1;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         $error("register %0d: expected %h, actual %h", addr, want, prdata);
      if (prdata !== want) error_count++;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Hold start for one transaction; optionally leave a random gap first.
   task automatic send_sample(input logic [31:0] sample, input bit allow_gap);
      if (allow_gap) begin
         while ($urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (busy);
      expected_q.push_back(convert_sample(sample));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (lds_pkg::LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] random_sample(int fs);
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(fs);
         2: return -$urandom_range(fs);
         3: return $urandom_range(3) - 1;
         4: return fs + $urandom_range(2) - 1;
         default: return $urandom_range(fs / 100 + 2);
      endcase
   endfunction

   // Result monitor
   always @(posedge clock) begin
      display_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result %h", rsp_display_value);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_display_value !== want.display_value) begin
               $error("display_value: expected %h, actual %h",
                      want.display_value, rsp_display_value);
               error_count++;
            end
            if (rsp_invalid !== want.invalid) begin
               $error("invalid: expected %b, actual %b", want.invalid, rsp_invalid);
               error_count++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %b, actual %b", want.saturated, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   typedef struct {
      logic [3:0]  mode;
      logic [30:0] full_scale;
      logic [31:0] sample;
      bit          typed;
      logic [31:0] display_value;
      logic        invalid;
      logic        saturated;
   } stim_row_type;

   stim_row_type directed[] = '{
      // reset settings: direct, value shifted up
      '{lds_pkg::MODE_DIRECT, 31'd8388608, 32'd1, 1'b1, 32'h0001_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_DIRECT, 31'd8388608, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1},
      '{lds_pkg::MODE_DIRECT, 31'd8388608, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, 1'b1},
      '{lds_pkg::MODE_NEGATE, 31'd8388608, 32'd0, 1'b1, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_NEGATE, 31'd8388608, 32'd2, 1'b1, 32'hFFFE_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_PERCENT, 31'd8388608, 32'd8388608, 1'b1, 32'h0064_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_PERCENT, 31'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB, 31'd1000, 32'd0, 1'b1, 32'hFF4C_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB, 31'd1000, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1, 1'b0},
      '{lds_pkg::MODE_DB, 31'd1000, 32'd1000, 1'b1, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB, 31'd1000, 32'd100, 1'b0, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB40, 31'd1000, 32'd1000, 1'b1, 32'h0028_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB40, 31'd1000, 32'd1001, 1'b1, 32'd0, 1'b1, 1'b0},
      '{lds_pkg::MODE_DB40, 31'd1000, -32'sd1000, 1'b1, 32'd0, 1'b1, 1'b0},
      '{lds_pkg::MODE_DB40, 31'd1000, 32'd0, 1'b1, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB40, 31'd1000, 32'd999, 1'b1, 32'h0028_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_DB40, 31'd1000, 32'd500, 1'b0, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_DIV318, 31'd1000, 32'd318, 1'b1, 32'h0001_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_MOD, 31'd1000, -32'sd340, 1'b1, 32'hFFFF_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_HALF, 31'd1000, 32'd5, 1'b1, 32'h0001_0000, 1'b0, 1'b0},
      '{lds_pkg::MODE_FLOOR, 31'd2000, 32'd1, 1'b1, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_FLOOR, 31'd2000, 32'd2, 1'b0, 32'd0, 1'b0, 1'b0},
      '{lds_pkg::MODE_FLOOR, 31'd2000, -32'sd5, 1'b1, 32'd0, 1'b0, 1'b0},
      '{4'd15, 31'd1, 32'd7, 1'b1, 32'h0007_0000, 1'b0, 1'b0}
   };

   initial begin
      logic [3:0]  mode_pick;
      logic [30:0] fs_pick;
      int          phase_items;
      error_count = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_sample <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      cur_mode = lds_pkg::MODE_DIRECT;
      cur_full_scale = 31'd8388608;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(ADDR_MODE, 32'd7);
      csr_check(ADDR_FULL_SCALE, 32'd8388608);

      foreach (directed[i]) begin
         if (directed[i].mode != cur_mode || directed[i].full_scale != cur_full_scale) begin
            drain();
            csr_write(ADDR_MODE, 32'(directed[i].mode));
            csr_write(ADDR_FULL_SCALE, 32'(directed[i].full_scale));
         end
         if (directed[i].typed) begin
            display_type typed_in;
            typed_in = convert_sample(directed[i].sample);
            // typed rows also cross-check the predictor
            if (typed_in.display_value !== directed[i].display_value ||
                typed_in.invalid !== directed[i].invalid ||
                typed_in.saturated !== directed[i].saturated) begin
               $error("row %0d: expected %h/%b/%b, predicted %h/%b/%b", i,
                      directed[i].display_value, directed[i].invalid,
                      directed[i].saturated, typed_in.display_value,
                      typed_in.invalid, typed_in.saturated);
               error_count++;
            end
         end
         send_sample(directed[i].sample, 1'b0);
      end

      for (int ph = 0; ph < 20; ph++) begin
         drain();
         mode_pick = (ph < 16) ? 4'(ph) : 4'($urandom_range(15));
         case (ph % 4)
            0: fs_pick = 31'h7FFF_FFFF;
            1: fs_pick = 31'd1;
            2: fs_pick = 31'($urandom_range(1000, 1));
            default: fs_pick = 31'($urandom);
         endcase
         csr_write(ADDR_MODE, 32'(mode_pick));
         csr_write(ADDR_FULL_SCALE, 32'(fs_pick));
         phase_items = 80;
         for (int k = 0; k < phase_items; k++)
            send_sample(random_sample(int'((fs_pick == 31'd0) ? 31'd1 : fs_pick)),
                        ph != 5 || k > 60);
      end
      drain();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
